// File: rtl/core/ssvo_pkg.sv
// shared types and constants for the sphere shell / voxel overlap block
// no dependencies; used by every other file of the block
package ssvo_pkg;

    // fixed field widths
    localparam int KW      = 13;  // voxel coordinate and origin width
    localparam int VW      = 16;  // voxel edge width
    localparam int CELLW   = 11;  // grid size width
    localparam int IDXW    = 32;  // linear index width
    localparam int CFG_DW  = 16;  // config write data width
    localparam int CFG_AW  = 3;   // config register index width

    // config register indexes
    localparam logic [CFG_AW-1:0] REG_VOXEL_SIZE = 3'd0;
    localparam logic [CFG_AW-1:0] REG_ORIGIN_VX  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_ORIGIN_VY  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_ORIGIN_VZ  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_CELLS_X    = 3'd4;
    localparam logic [CFG_AW-1:0] REG_CELLS_Y    = 3'd5;

    // config reset values
    localparam logic [VW-1:0]    RST_VOXEL_SIZE = 16'd256;
    localparam logic [KW-1:0]    RST_ORIGIN     = 13'd0;
    localparam logic [CELLW-1:0] RST_CELLS      = 11'd64;

    // number of pipeline stages
    localparam int NSTG = 4;

    typedef struct packed {
        logic [VW-1:0]           voxel_size;
        logic signed [KW-1:0]    origin_vx;
        logic signed [KW-1:0]    origin_vy;
        logic signed [KW-1:0]    origin_vz;
        logic [CELLW-1:0]        cells_x;
        logic [CELLW-1:0]        cells_y;
    } t_cfg;

endpackage

// File: rtl/core/ssvo_in_if.sv
// input channel of the sphere shell / voxel overlap block
// depends on ssvo_pkg for the fixed field widths
interface ssvo_in_if #(
    parameter int CW = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [CW-1:0]           center_x;
    logic signed [CW-1:0]           center_y;
    logic signed [CW-1:0]           center_z;
    logic [CW-2:0]                  sphere_radius;
    logic signed [ssvo_pkg::KW-1:0] voxel_kx;
    logic signed [ssvo_pkg::KW-1:0] voxel_ky;
    logic signed [ssvo_pkg::KW-1:0] voxel_kz;

    modport source (
        output valid, center_x, center_y, center_z, sphere_radius,
               voxel_kx, voxel_ky, voxel_kz,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, center_z, sphere_radius,
               voxel_kx, voxel_ky, voxel_kz,
        output ready
    );
endinterface

// File: rtl/core/ssvo_out_if.sv
// result channel of the sphere shell / voxel overlap block
// depends on ssvo_pkg for the index width
interface ssvo_out_if;
    logic                             valid;
    logic                             ready;
    logic                             overlap;
    logic signed [ssvo_pkg::IDXW-1:0] linear_index;

    modport source (
        output valid, overlap, linear_index,
        input  ready
    );
    modport sink (
        input  valid, overlap, linear_index,
        output ready
    );
endinterface

// File: rtl/core/ssvo_cfg.sv
// configuration register file of the sphere shell / voxel overlap block
// depends on ssvo_pkg for register indexes, reset values and t_cfg
module ssvo_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ssvo_pkg::CFG_AW-1:0]   i_cfg_idx,
    input  logic [ssvo_pkg::CFG_DW-1:0]   i_cfg_wdata,
    output ssvo_pkg::t_cfg                o_cfg
);

    ssvo_pkg::t_cfg r_cfg;
    ssvo_pkg::t_cfg n_cfg;

    // decode the write, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                ssvo_pkg::REG_VOXEL_SIZE: n_cfg.voxel_size = i_cfg_wdata;
                ssvo_pkg::REG_ORIGIN_VX:  n_cfg.origin_vx  = i_cfg_wdata[ssvo_pkg::KW-1:0];
                ssvo_pkg::REG_ORIGIN_VY:  n_cfg.origin_vy  = i_cfg_wdata[ssvo_pkg::KW-1:0];
                ssvo_pkg::REG_ORIGIN_VZ:  n_cfg.origin_vz  = i_cfg_wdata[ssvo_pkg::KW-1:0];
                ssvo_pkg::REG_CELLS_X:    n_cfg.cells_x    = i_cfg_wdata[ssvo_pkg::CELLW-1:0];
                ssvo_pkg::REG_CELLS_Y:    n_cfg.cells_y    = i_cfg_wdata[ssvo_pkg::CELLW-1:0];
                default: ;
            endcase
        end
    end

    // register state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.voxel_size <= ssvo_pkg::RST_VOXEL_SIZE;
            r_cfg.origin_vx  <= ssvo_pkg::RST_ORIGIN;
            r_cfg.origin_vy  <= ssvo_pkg::RST_ORIGIN;
            r_cfg.origin_vz  <= ssvo_pkg::RST_ORIGIN;
            r_cfg.cells_x    <= ssvo_pkg::RST_CELLS;
            r_cfg.cells_y    <= ssvo_pkg::RST_CELLS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/ssvo_geom.sv
// four-stage datapath for the shell cut and the sphere/box overlap test
// depends on ssvo_pkg for field widths and stage count
module ssvo_geom #(
    parameter int CW = 24
) (
    input  logic                           i_clk,
    input  logic [ssvo_pkg::NSTG-1:0]      i_adv,
    input  logic signed [CW-1:0]           i_center_x,
    input  logic signed [CW-1:0]           i_center_y,
    input  logic signed [CW-1:0]           i_center_z,
    input  logic [CW-2:0]                  i_sphere_radius,
    input  logic signed [ssvo_pkg::KW-1:0] i_voxel_kx,
    input  logic signed [ssvo_pkg::KW-1:0] i_voxel_ky,
    input  logic signed [ssvo_pkg::KW-1:0] i_voxel_kz,
    input  logic [ssvo_pkg::VW-1:0]        i_voxel_size,
    output logic                           o_overlap
);

    localparam int KW = ssvo_pkg::KW;
    localparam int VW = ssvo_pkg::VW;
    localparam int RW = CW - 1;
    // k * v, signed
    localparam int PW = KW + VW + 1;
    // 2r - 3v
    localparam int TW = ((CW > VW + 2) ? CW : VW + 2) + 2;
    // doubled center offset (2k+1)v - 2s
    localparam int DW = ((PW + 1 > CW) ? PW + 1 : CW) + 2;
    // per-axis gap against [kv, kv+v]
    localparam int GW = ((PW + 1 > CW) ? PW + 1 : CW) + 1;
    localparam int SQD = 2 * CW;
    localparam int SQG = 2 * RW;

    logic signed [CW-1:0] s_in [3];
    logic signed [KW-1:0] k_in [3];

    assign s_in[0] = i_center_x;
    assign s_in[1] = i_center_y;
    assign s_in[2] = i_center_z;
    assign k_in[0] = i_voxel_kx;
    assign k_in[1] = i_voxel_ky;
    assign k_in[2] = i_voxel_kz;

    // stage 1: box corners and shell threshold
    logic signed [PW-1:0] n1_lo [3];
    logic signed [TW-1:0] n1_t;
    logic [TW-1:0]        n1_v3;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_lo[i] = $signed(PW'(k_in[i])) * $signed(PW'({1'b0, i_voxel_size}));
        end
        n1_v3 = TW'({i_voxel_size, 1'b0}) + TW'(i_voxel_size);
        n1_t  = $signed(TW'({i_sphere_radius, 1'b0}) - n1_v3);
    end

    logic signed [CW-1:0] r1_s [3];
    logic signed [PW-1:0] r1_lo [3];
    logic [RW-1:0]        r1_r;
    logic [CW-1:0]        r1_t;
    logic                 r1_tpos;
    logic [VW-1:0]        r1_v;

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r1_s    <= s_in;
            r1_lo   <= n1_lo;
            r1_r    <= i_sphere_radius;
            r1_t    <= n1_t[CW-1:0];
            r1_tpos <= !n1_t[TW-1] && (n1_t != '0);
            r1_v    <= i_voxel_size;
        end
    end

    // stage 2: center offsets against the threshold, gaps against the radius
    logic signed [DW-1:0] n2_d [3];
    logic [DW-1:0]        n2_ad [3];
    logic signed [GW-1:0] n2_sx [3];
    logic signed [GW-1:0] n2_lo [3];
    logic signed [GW-1:0] n2_hi [3];
    logic signed [GW-1:0] n2_g [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_d[i]  = ($signed(DW'(r1_lo[i])) <<< 1) + $signed(DW'({1'b0, r1_v}))
                     - ($signed(DW'(r1_s[i])) <<< 1);
            n2_ad[i] = n2_d[i][DW-1] ? DW'(-n2_d[i]) : DW'(n2_d[i]);
            n2_sx[i] = $signed(GW'(r1_s[i]));
            n2_lo[i] = $signed(GW'(r1_lo[i]));
            n2_hi[i] = n2_lo[i] + $signed(GW'({1'b0, r1_v}));
            if (n2_sx[i] < n2_lo[i]) begin
                n2_g[i] = n2_lo[i] - n2_sx[i];
            end else if (n2_sx[i] > n2_hi[i]) begin
                n2_g[i] = n2_sx[i] - n2_hi[i];
            end else begin
                n2_g[i] = '0;
            end
        end
    end

    logic [CW-1:0] r2_ad [3];
    logic [2:0]    r2_near;
    logic [RW-1:0] r2_g [3];
    logic [2:0]    r2_far;
    logic [RW-1:0] r2_r;
    logic [CW-1:0] r2_t;
    logic          r2_tpos;

    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            for (int i = 0; i < 3; i++) begin
                r2_ad[i]   <= n2_ad[i][CW-1:0];
                r2_near[i] <= n2_ad[i] < DW'(r1_t);
                r2_g[i]    <= n2_g[i][RW-1:0];
                r2_far[i]  <= $unsigned(n2_g[i]) >= GW'(r1_r);
            end
            r2_r    <= r1_r;
            r2_t    <= r1_t;
            r2_tpos <= r1_tpos;
        end
    end

    // stage 3: squares
    logic [SQD-1:0] r3_dsq [3];
    logic [SQG-1:0] r3_gsq [3];
    logic [SQD-1:0] r3_tsq;
    logic [SQG-1:0] r3_rsq;
    logic           r3_inner;
    logic           r3_far;

    always_ff @(posedge i_clk) begin
        if (i_adv[2]) begin
            for (int i = 0; i < 3; i++) begin
                r3_dsq[i] <= SQD'(r2_ad[i]) * SQD'(r2_ad[i]);
                r3_gsq[i] <= SQG'(r2_g[i]) * SQG'(r2_g[i]);
            end
            r3_tsq   <= SQD'(r2_t) * SQD'(r2_t);
            r3_rsq   <= SQG'(r2_r) * SQG'(r2_r);
            r3_inner <= r2_tpos && (&r2_near);
            r3_far   <= |r2_far;
        end
    end

    // stage 4: sums and final decision
    logic [SQD+1:0] n4_dsum;
    logic [SQG+1:0] n4_gsum;
    logic           n4_cut;
    logic           n4_hit;

    always_comb begin
        n4_dsum = (SQD + 2)'(r3_dsq[0]) + (SQD + 2)'(r3_dsq[1]) + (SQD + 2)'(r3_dsq[2]);
        n4_gsum = (SQG + 2)'(r3_gsq[0]) + (SQG + 2)'(r3_gsq[1]) + (SQG + 2)'(r3_gsq[2]);
        n4_cut  = r3_inner && (n4_dsum < (SQD + 2)'(r3_tsq));
        n4_hit  = !r3_far && (n4_gsum < (SQG + 2)'(r3_rsq));
    end

    logic r4_ov;

    always_ff @(posedge i_clk) begin
        if (i_adv[3]) begin
            r4_ov <= n4_hit && !n4_cut;
        end
    end

    assign o_overlap = r4_ov;

endmodule

// File: rtl/core/ssvo_index.sv
// four-stage linear grid index path, wraps at 32 bits
// depends on ssvo_pkg for field widths, stage count and t_cfg
module ssvo_index (
    input  logic                             i_clk,
    input  logic [ssvo_pkg::NSTG-1:0]        i_adv,
    input  logic signed [ssvo_pkg::KW-1:0]   i_voxel_kx,
    input  logic signed [ssvo_pkg::KW-1:0]   i_voxel_ky,
    input  logic signed [ssvo_pkg::KW-1:0]   i_voxel_kz,
    input  ssvo_pkg::t_cfg                   i_cfg,
    output logic signed [ssvo_pkg::IDXW-1:0] o_linear_index
);

    localparam int KW   = ssvo_pkg::KW;
    localparam int AW   = KW + 1;
    localparam int CLW  = ssvo_pkg::CELLW;
    localparam int IDXW = ssvo_pkg::IDXW;

    // per-axis offset, negative offsets move one toward zero
    function automatic logic signed [AW-1:0] axis_off(
        input logic signed [KW-1:0] k,
        input logic signed [KW-1:0] org
    );
        logic signed [AW-1:0] d;
        d = $signed(AW'(k)) - $signed(AW'(org));
        if (d[AW-1]) begin
            d = d + AW'(1);
        end
        return d;
    endfunction

    // stage 1: axis offsets and plane size
    logic signed [AW-1:0]  r1_ix, r1_iy, r1_iz;
    logic [2*CLW-1:0]      r1_cxy;
    logic [CLW-1:0]        r1_cx;

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r1_ix  <= axis_off(i_voxel_kx, i_cfg.origin_vx);
            r1_iy  <= axis_off(i_voxel_ky, i_cfg.origin_vy);
            r1_iz  <= axis_off(i_voxel_kz, i_cfg.origin_vz);
            r1_cxy <= (2 * CLW)'(i_cfg.cells_x) * (2 * CLW)'(i_cfg.cells_y);
            r1_cx  <= i_cfg.cells_x;
        end
    end

    // stage 2: row term
    logic [IDXW-1:0]      r2_ix;
    logic [IDXW-1:0]      r2_iyc;
    logic signed [AW-1:0] r2_iz;
    logic [2*CLW-1:0]     r2_cxy;

    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            r2_ix  <= IDXW'(r1_ix);
            r2_iyc <= IDXW'(r1_iy) * IDXW'(r1_cx);
            r2_iz  <= r1_iz;
            r2_cxy <= r1_cxy;
        end
    end

    // stage 3: plane term and partial sum
    logic [IDXW-1:0] r3_izc;
    logic [IDXW-1:0] r3_part;

    always_ff @(posedge i_clk) begin
        if (i_adv[2]) begin
            r3_izc  <= IDXW'(r2_iz) * IDXW'(r2_cxy);
            r3_part <= r2_ix + r2_iyc;
        end
    end

    // stage 4: final sum
    logic [IDXW-1:0] r4_idx;

    always_ff @(posedge i_clk) begin
        if (i_adv[3]) begin
            r4_idx <= r3_part + r3_izc;
        end
    end

    assign o_linear_index = $signed(r4_idx);

endmodule

// File: rtl/core/sphere_shell_voxel_overlap.sv
// top level of the sphere shell / voxel overlap block
// depends on ssvo_pkg, ssvo_in_if, ssvo_out_if, ssvo_cfg, ssvo_geom, ssvo_index
//
//  channel   dir  handshake      payload
//  i_item    in   valid/ready    center_x/y/z, sphere_radius, voxel_kx/ky/kz
//  o_res     out  valid/ready    overlap, linear_index
//  i_cfg_*   in   write enable   register index, write data
//
// one transaction per cycle sustained while o_res.ready is high; four register
// stages, the last one being the output register
// each stage holds its transaction while the next stage is full and stalled, and
// empty stages fill in behind a stalled output, so bubbles collapse
// synchronous reset empties the pipeline and loads the config defaults
module sphere_shell_voxel_overlap #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ssvo_in_if.sink                       i_item,
    ssvo_out_if.source                    o_res,
    input  logic                          i_cfg_we,
    input  logic [ssvo_pkg::CFG_AW-1:0]   i_cfg_idx,
    input  logic [ssvo_pkg::CFG_DW-1:0]   i_cfg_wdata
);

    localparam int NSTG = ssvo_pkg::NSTG;

    ssvo_pkg::t_cfg  cfg;
    logic [NSTG-1:0] adv;
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;

    // stage load enables: a stage loads when empty or when it empties this cycle
    always_comb begin
        adv[NSTG-1] = !r_vld[NSTG-1] || o_res.ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            adv[i] = !r_vld[i] || adv[i+1];
        end
    end

    // valid bits travel with the data
    always_comb begin
        n_vld = r_vld;
        if (adv[0]) begin
            n_vld[0] = i_item.valid;
        end
        for (int i = 1; i < NSTG; i++) begin
            if (adv[i]) begin
                n_vld[i] = r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_item.ready = adv[0];
    assign o_res.valid  = r_vld[NSTG-1];

    // configuration registers
    ssvo_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // overlap datapath
    ssvo_geom #(
        .CW (COORD_WIDTH)
    ) u_geom (
        .i_clk           (i_clk),
        .i_adv           (adv),
        .i_center_x      (i_item.center_x),
        .i_center_y      (i_item.center_y),
        .i_center_z      (i_item.center_z),
        .i_sphere_radius (i_item.sphere_radius),
        .i_voxel_kx      (i_item.voxel_kx),
        .i_voxel_ky      (i_item.voxel_ky),
        .i_voxel_kz      (i_item.voxel_kz),
        .i_voxel_size    (cfg.voxel_size),
        .o_overlap       (o_res.overlap)
    );

    // grid index datapath
    ssvo_index u_index (
        .i_clk          (i_clk),
        .i_adv          (adv),
        .i_voxel_kx     (i_item.voxel_kx),
        .i_voxel_ky     (i_item.voxel_ky),
        .i_voxel_kz     (i_item.voxel_kz),
        .i_cfg          (cfg),
        .o_linear_index (o_res.linear_index)
    );

    // an accepted transaction lands in the first stage
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> r_vld[0])
        else $error("accepted transaction missing from first stage");

    // input back-pressure only when every stage is full and the output is stalled
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> ((&r_vld) && !o_res.ready))
        else $error("input stalled with room in the pipeline");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

endmodule
